[rtl/core/nrsu_pkg.sv]
// Shared types and constants for the normalized relative strength unit.
package nrsu_pkg;

   localparam int DIV_NW = 73;
   localparam int DIV_DW = 32;
   localparam int DIV_CW = 7;

   localparam logic [DIV_CW-1:0] DIV_BITS_ATR   = 7'd40;
   localparam logic [DIV_CW-1:0] DIV_BITS_RET   = 7'd56;
   localparam logic [DIV_CW-1:0] DIV_BITS_RATIO = 7'd73;
   localparam logic [DIV_CW-1:0] DIV_BITS_MEAN  = 7'd56;
   localparam logic [DIV_CW-1:0] DIV_BITS_EMA   = 7'd50;

   localparam logic [57:0] ONE_Q24 = 58'd16777216;
   localparam logic [DIV_NW-1:0] POS_LIM = 73'(64'h0000_7FFF_FFFF_FFFF);
   localparam logic [DIV_NW-1:0] NEG_LIM = 73'(64'h0000_8000_0000_0000);

   localparam logic [7:0] CSR_RETURN_LAG      = 8'd0;
   localparam logic [7:0] CSR_RANGE_LENGTH    = 8'd1;
   localparam logic [7:0] CSR_SMOOTH_LENGTH   = 8'd2;
   localparam logic [7:0] CSR_USE_EXPONENTIAL = 8'd3;

   typedef struct packed {
      logic [31:0] high_price;
      logic [31:0] low_price;
      logic [31:0] close_price;
      logic [31:0] bench_close;
   } req_payload_type;

   typedef struct packed {
      logic signed [47:0] smoothed_value;
      logic               signal_long;
   } rsp_payload_type;

   typedef struct packed {
      logic              start;
      logic [DIV_NW-1:0] dividend;
      logic [DIV_DW-1:0] divisor;
      logic [DIV_CW-1:0] nbits;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIV_NW-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_RANGE,
      S_ATR,
      S_ATR_ADD,
      S_ATR_WAIT,
      S_RET_S,
      S_RET_S_WAIT,
      S_RET_B,
      S_RET_B_WAIT,
      S_RATIO,
      S_RATIO_WAIT,
      S_RING,
      S_SUM_RD,
      S_SUM_ACC,
      S_MEAN,
      S_MEAN_WAIT,
      S_EMA,
      S_EMA_WAIT,
      S_DONE
   } state_type;

endpackage

[rtl/core/nrsu_divider.sv]
// Shared restoring divider, one quotient bit per cycle, left-aligned dividend.
module nrsu_divider import nrsu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] count_ff, count_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] divisor_ff, divisor_in;
   logic [DIV_NW-1:0] dq_ff, dq_in;
   logic [DIV_DW:0]   trial;
   logic [DIV_DW:0]   diff;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      dq_in      = dq_ff;
      trial      = {rem_ff, dq_ff[DIV_NW-1]};
      diff       = trial - {1'b0, divisor_ff};
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = div_req.nbits;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         dq_in      = div_req.dividend;
      end else if (busy_ff) begin
         if (!diff[DIV_DW]) begin
            rem_in = diff[DIV_DW-1:0];
            dq_in  = {dq_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DW-1:0];
            dq_in  = {dq_ff[DIV_NW-2:0], 1'b0};
         end
         count_in = count_ff - 7'd1;
         if (count_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      dq_ff      <= dq_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dq_ff;

endmodule

[rtl/core/atr_normalized_relative_strength_unit.sv]
// Top level: bar sequencer, close and ratio rings, result register.
// Each bar runs the sequencing states plus one divider pass per division (up to six
// passes) plus a ratio summation over the last effective smooth_length ratios.
// Bars: one at a time, since all divisions share one divider. A new bar is taken
// once the previous result is loaded into the output register.
// Reset: synchronous; clears control state and restores register defaults; rings hold
// no reset value and are read only after being written.
module atr_normalized_relative_strength_unit import nrsu_pkg::*; #(
   parameter int MAX_LAG    = 64,
   parameter int MAX_SMOOTH = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [7:0]      csr_index,
   input  logic [7:0]      csr_wdata
);

   localparam int LAG_AW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
   localparam int SM_AW  = (MAX_SMOOTH > 1) ? $clog2(MAX_SMOOTH) : 1;

   logic [6:0] return_lag_ff;
   logic [7:0] range_length_ff;
   logic [6:0] smooth_length_ff;
   logic       use_exponential_ff;

   state_type state_ff, state_in;

   req_payload_type bar_ff, bar_in;
   logic [31:0]     prev_close_ff, prev_close_in;
   logic [7:0]      bar_count_ff, bar_count_in;
   logic [39:0]     range_sum_ff, range_sum_in;
   logic [31:0]     avg_ff, avg_in;
   logic            range_ready_ff, range_ready_in;
   logic            ema_ready_ff, ema_ready_in;
   logic [LAG_AW-1:0] lag_slot_ff, lag_slot_in;
   logic [SM_AW-1:0]  smooth_slot_ff, smooth_slot_in;
   logic [SM_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [6:0]      cnt_ff, cnt_in;
   logic [31:0]     tr_ff, tr_in;
   logic [39:0]     prod_ff, prod_in;
   logic            seed_ff, seed_in;
   logic [57:0]     sret_ff, sret_in;
   logic [57:0]     bret_ff, bret_in;
   logic            neg_ff, neg_in;
   logic [47:0]     ratio_ff, ratio_in;
   logic [55:0]     sum_ff, sum_in;
   logic [47:0]     mean_ff, mean_in;
   logic [47:0]     ema_ff, ema_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic [31:0] stock_mem [MAX_LAG];
   logic [31:0] bench_mem [MAX_LAG];
   logic [47:0] ratio_mem [MAX_SMOOTH];
   logic [31:0] stock_rd_ff;
   logic [31:0] bench_rd_ff;
   logic [47:0] ratio_rd_ff;
   logic              lag_rd_en, lag_wr_en, sm_rd_en, sm_wr_en;
   logic [LAG_AW-1:0] lag_rd_addr;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [6:0]  lag_eff;
   logic [7:0]  len_eff;
   logic [7:0]  len_m1;
   logic [6:0]  p_eff;
   logic [7:0]  p_plus;
   logic        lag_ok;
   logic        window_full;
   logic [31:0] lag_slot_w, lag_w, lag_back;
   logic [31:0] hl, dh, dl, tr_max;
   logic [39:0] sum_new;
   logic [57:0] diff58, mag58;
   logic [DIV_NW-1:0] lim, res;
   logic [47:0] res48;
   logic [55:0] sum_mag;
   logic [49:0] ema_diff, ema_mag, ema_upd, ema_sum;
   logic [47:0] value;

   nrsu_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         return_lag_ff      <= 7'd14;
         range_length_ff    <= 8'd14;
         smooth_length_ff   <= 7'd5;
         use_exponential_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RETURN_LAG:      return_lag_ff      <= csr_wdata[6:0];
            CSR_RANGE_LENGTH:    range_length_ff    <= csr_wdata;
            CSR_SMOOTH_LENGTH:   smooth_length_ff   <= csr_wdata[6:0];
            CSR_USE_EXPONENTIAL: use_exponential_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      lag_eff = (32'(return_lag_ff) > 32'(MAX_LAG)) ? 7'(MAX_LAG) : return_lag_ff;
      len_eff = (range_length_ff == 8'd0) ? 8'd1 : range_length_ff;
      len_m1  = len_eff - 8'd1;
      if (smooth_length_ff == 7'd0) begin
         p_eff = 7'd1;
      end else if (32'(smooth_length_ff) > 32'(MAX_SMOOTH)) begin
         p_eff = 7'(MAX_SMOOTH);
      end else begin
         p_eff = smooth_length_ff;
      end
      p_plus      = {1'b0, p_eff} + 8'd1;
      lag_ok      = (lag_eff != 7'd0) && (bar_count_ff >= {1'b0, lag_eff});
      window_full = ({1'b0, bar_count_ff} + 9'd1) >= {2'b0, p_eff};
      lag_slot_w  = 32'(lag_slot_ff);
      lag_w       = 32'(lag_eff);
      lag_back    = (lag_slot_w >= lag_w) ? lag_slot_w - lag_w
                                          : lag_slot_w + 32'(MAX_LAG) - lag_w;
      lag_rd_addr = lag_back[LAG_AW-1:0];
   end

   always_comb begin
      hl = (bar_ff.high_price >= bar_ff.low_price) ? bar_ff.high_price - bar_ff.low_price
                                                   : 32'd0;
      dh = (bar_ff.high_price >= prev_close_ff) ? bar_ff.high_price - prev_close_ff
                                                : prev_close_ff - bar_ff.high_price;
      dl = (bar_ff.low_price >= prev_close_ff) ? bar_ff.low_price - prev_close_ff
                                               : prev_close_ff - bar_ff.low_price;
      tr_max = hl;
      if (dh > tr_max) tr_max = dh;
      if (dl > tr_max) tr_max = dl;
   end

   always_comb begin
      state_in       = state_ff;
      bar_in         = bar_ff;
      prev_close_in  = prev_close_ff;
      bar_count_in   = bar_count_ff;
      range_sum_in   = range_sum_ff;
      avg_in         = avg_ff;
      range_ready_in = range_ready_ff;
      ema_ready_in   = ema_ready_ff;
      lag_slot_in    = lag_slot_ff;
      smooth_slot_in = smooth_slot_ff;
      rd_ptr_in      = rd_ptr_ff;
      cnt_in         = cnt_ff;
      tr_in          = tr_ff;
      prod_in        = prod_ff;
      seed_in        = seed_ff;
      sret_in        = sret_ff;
      bret_in        = bret_ff;
      neg_in         = neg_ff;
      ratio_in       = ratio_ff;
      sum_in         = sum_ff;
      mean_in        = mean_ff;
      ema_in         = ema_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      lag_rd_en      = 1'b0;
      lag_wr_en      = 1'b0;
      sm_rd_en       = 1'b0;
      sm_wr_en       = 1'b0;
      div_req        = '0;
      req_ready      = (state_ff == S_IDLE);
      sum_new        = range_sum_ff + {8'b0, tr_ff};
      diff58         = sret_ff - bret_ff;
      mag58          = diff58[57] ? (58'd0 - diff58) : diff58;
      lim            = neg_ff ? NEG_LIM : POS_LIM;
      res            = (div_rsp.quotient > lim) ? lim : div_rsp.quotient;
      res48          = res[47:0];
      sum_mag        = sum_ff[55] ? (56'd0 - sum_ff) : sum_ff;
      ema_diff       = ({{2{ratio_ff[47]}}, ratio_ff} - {{2{ema_ff[47]}}, ema_ff}) << 1;
      ema_mag        = ema_diff[49] ? (50'd0 - ema_diff) : ema_diff;
      ema_upd        = neg_ff ? (50'd0 - div_rsp.quotient[49:0]) : div_rsp.quotient[49:0];
      ema_sum        = {{2{ema_ff[47]}}, ema_ff} + ema_upd;
      value          = use_exponential_ff ? ema_ff : mean_ff;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               bar_in   = req_payload;
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            tr_in     = (bar_count_ff == 8'd0) ? 32'd0 : tr_max;
            lag_rd_en = 1'b1;
            state_in  = S_ATR;
         end
         S_ATR: begin
            if (range_ready_ff) begin
               prod_in  = {8'b0, avg_ff} * {32'b0, len_m1};
               state_in = S_ATR_ADD;
            end else begin
               range_sum_in = sum_new;
               if (bar_count_ff >= len_eff) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {sum_new, 33'b0};
                  div_req.divisor  = {24'b0, len_eff};
                  div_req.nbits    = DIV_BITS_ATR;
                  seed_in          = 1'b1;
                  state_in         = S_ATR_WAIT;
               end else begin
                  state_in = S_RET_S;
               end
            end
         end
         S_ATR_ADD: begin
            div_req.start    = 1'b1;
            div_req.dividend = {prod_ff + {8'b0, tr_ff}, 33'b0};
            div_req.divisor  = {24'b0, len_eff};
            div_req.nbits    = DIV_BITS_ATR;
            seed_in          = 1'b0;
            state_in         = S_ATR_WAIT;
         end
         S_ATR_WAIT: begin
            if (div_rsp.done) begin
               if (seed_ff) begin
                  avg_in = (|div_rsp.quotient[39:32]) ? 32'hFFFF_FFFF
                                                      : div_rsp.quotient[31:0];
                  range_ready_in = 1'b1;
               end else begin
                  avg_in = div_rsp.quotient[31:0];
               end
               state_in = S_RET_S;
            end
         end
         S_RET_S: begin
            lag_wr_en   = 1'b1;
            lag_slot_in = (lag_slot_ff == LAG_AW'(MAX_LAG - 1)) ? '0
                        : LAG_AW'(lag_slot_w + 32'd1);
            if (lag_ok && stock_rd_ff != 32'd0) begin
               div_req.start    = 1'b1;
               div_req.dividend = {bar_ff.close_price, 41'b0};
               div_req.divisor  = stock_rd_ff;
               div_req.nbits    = DIV_BITS_RET;
               state_in         = S_RET_S_WAIT;
            end else begin
               sret_in  = '0;
               state_in = S_RET_B;
            end
         end
         S_RET_S_WAIT: begin
            if (div_rsp.done) begin
               sret_in  = {2'b0, div_rsp.quotient[55:0]} - ONE_Q24;
               state_in = S_RET_B;
            end
         end
         S_RET_B: begin
            if (lag_ok && bench_rd_ff != 32'd0) begin
               div_req.start    = 1'b1;
               div_req.dividend = {bar_ff.bench_close, 41'b0};
               div_req.divisor  = bench_rd_ff;
               div_req.nbits    = DIV_BITS_RET;
               state_in         = S_RET_B_WAIT;
            end else begin
               bret_in  = '0;
               state_in = S_RATIO;
            end
         end
         S_RET_B_WAIT: begin
            if (div_rsp.done) begin
               bret_in  = {2'b0, div_rsp.quotient[55:0]} - ONE_Q24;
               state_in = S_RATIO;
            end
         end
         S_RATIO: begin
            neg_in = diff58[57];
            if (avg_ff == 32'd0) begin
               ratio_in = '0;
               state_in = S_RING;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = {mag58[56:0], 16'b0};
               div_req.divisor  = avg_ff;
               div_req.nbits    = DIV_BITS_RATIO;
               state_in         = S_RATIO_WAIT;
            end
         end
         S_RATIO_WAIT: begin
            if (div_rsp.done) begin
               ratio_in = neg_ff ? (48'd0 - res48) : res48;
               state_in = S_RING;
            end
         end
         S_RING: begin
            sm_wr_en       = 1'b1;
            rd_ptr_in      = smooth_slot_ff;
            smooth_slot_in = (smooth_slot_ff == SM_AW'(MAX_SMOOTH - 1)) ? '0
                           : SM_AW'(32'(smooth_slot_ff) + 32'd1);
            sum_in         = '0;
            cnt_in         = p_eff;
            if (window_full) begin
               state_in = S_SUM_RD;
            end else begin
               mean_in  = '0;
               state_in = S_EMA;
            end
         end
         S_SUM_RD: begin
            sm_rd_en = 1'b1;
            state_in = S_SUM_ACC;
         end
         S_SUM_ACC: begin
            sum_in    = sum_ff + {{8{ratio_rd_ff[47]}}, ratio_rd_ff};
            rd_ptr_in = (rd_ptr_ff == '0) ? SM_AW'(MAX_SMOOTH - 1)
                      : SM_AW'(32'(rd_ptr_ff) - 32'd1);
            cnt_in    = cnt_ff - 7'd1;
            state_in  = (cnt_ff == 7'd1) ? S_MEAN : S_SUM_RD;
         end
         S_MEAN: begin
            div_req.start    = 1'b1;
            div_req.dividend = {sum_mag, 17'b0};
            div_req.divisor  = {25'b0, p_eff};
            div_req.nbits    = DIV_BITS_MEAN;
            state_in         = S_MEAN_WAIT;
         end
         S_MEAN_WAIT: begin
            if (div_rsp.done) begin
               mean_in  = sum_ff[55] ? (48'd0 - div_rsp.quotient[47:0])
                                     : div_rsp.quotient[47:0];
               state_in = S_EMA;
            end
         end
         S_EMA: begin
            if (ema_ready_ff) begin
               neg_in           = ema_diff[49];
               div_req.start    = 1'b1;
               div_req.dividend = {ema_mag, 23'b0};
               div_req.divisor  = {24'b0, p_plus};
               div_req.nbits    = DIV_BITS_EMA;
               state_in         = S_EMA_WAIT;
            end else begin
               if (window_full) begin
                  ema_in       = mean_ff;
                  ema_ready_in = 1'b1;
               end
               state_in = S_DONE;
            end
         end
         S_EMA_WAIT: begin
            if (div_rsp.done) begin
               ema_in   = ema_sum[47:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                  = 1'b1;
               rsp_payload_in.smoothed_value = value;
               rsp_payload_in.signal_long    = !value[47];
               bar_count_in  = (bar_count_ff == 8'hFF) ? 8'hFF : bar_count_ff + 8'd1;
               prev_close_in = bar_ff.close_price;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         prev_close_ff  <= '0;
         bar_count_ff   <= '0;
         range_sum_ff   <= '0;
         avg_ff         <= '0;
         range_ready_ff <= 1'b0;
         ema_ready_ff   <= 1'b0;
         lag_slot_ff    <= '0;
         smooth_slot_ff <= '0;
         ema_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         prev_close_ff  <= prev_close_in;
         bar_count_ff   <= bar_count_in;
         range_sum_ff   <= range_sum_in;
         avg_ff         <= avg_in;
         range_ready_ff <= range_ready_in;
         ema_ready_ff   <= ema_ready_in;
         lag_slot_ff    <= lag_slot_in;
         smooth_slot_ff <= smooth_slot_in;
         ema_ff         <= ema_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bar_ff         <= bar_in;
      rd_ptr_ff      <= rd_ptr_in;
      cnt_ff         <= cnt_in;
      tr_ff          <= tr_in;
      prod_ff        <= prod_in;
      seed_ff        <= seed_in;
      sret_ff        <= sret_in;
      bret_ff        <= bret_in;
      neg_ff         <= neg_in;
      ratio_ff       <= ratio_in;
      sum_ff         <= sum_in;
      mean_ff        <= mean_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_ff @(posedge clock) begin
      if (lag_wr_en) begin
         stock_mem[lag_slot_ff] <= bar_ff.close_price;
         bench_mem[lag_slot_ff] <= bar_ff.bench_close;
      end
      if (lag_rd_en) begin
         stock_rd_ff <= stock_mem[lag_rd_addr];
         bench_rd_ff <= bench_mem[lag_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (sm_wr_en) ratio_mem[smooth_slot_ff] <= ratio_ff;
      if (sm_rd_en) ratio_rd_ff <= ratio_mem[rd_ptr_ff];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("bar transfer did not make the unit busy");

   assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_ATR_WAIT || state_ff == S_RET_S_WAIT ||
                        state_ff == S_RET_B_WAIT || state_ff == S_RATIO_WAIT ||
                        state_ff == S_MEAN_WAIT || state_ff == S_EMA_WAIT))
      else $error("divider finished outside a wait state");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && !rsp_valid_ff |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished bar not loaded into result register");
`endif

endmodule
